[hdl/pixel_color_adjust_unit_macros.svh]
// Assertion macros used by the pixel color adjust top level.
`ifndef PIXEL_COLOR_ADJUST_UNIT_MACROS_SVH
`define PIXEL_COLOR_ADJUST_UNIT_MACROS_SVH

`ifndef SYNTH
// Antecedent in one cycle implies the consequent in the next cycle.
`define PCA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel color adjust: next-cycle check failed");
// Antecedent implies the consequent in the same cycle.
`define PCA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel color adjust: same-cycle check failed");
`else
`define PCA_ASSERT_NEXT(lbl, ante, cons)
`define PCA_ASSERT_NOW(lbl, ante, cons)
`endif

`endif

[hdl/pca_pkg.sv]
// Package with constants, types and register codes of the pixel color adjust unit.
`default_nettype none

package pca_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int HALF      = ONE / 2;
    localparam int TENTH     = (ONE + 5) / 10;
    localparam int TWENTIETH = (ONE * 5 + 50) / 100;

    localparam int PIX_W      = 13;
    localparam int ADJ_W      = 14;
    localparam int SLV_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [PIX_W-1:0]        ONE_PIX   = PIX_W'(ONE);
    localparam logic signed [SLV_W-1:0] SLV_MIN   = SLV_W'(-TENTH);
    localparam logic signed [SLV_W-1:0] SLV_MAX   = SLV_W'(TENTH);
    localparam logic [PIX_W-1:0]        WHITE_MIN = PIX_W'(ONE - TENTH);
    localparam logic [PIX_W-1:0]        WHITE_MAX = PIX_W'(ONE + TENTH);
    localparam logic [PIX_W-1:0]        GAIN_MIN  = PIX_W'(ONE - TWENTIETH);
    localparam logic [PIX_W-1:0]        GAIN_MAX  = PIX_W'(ONE + TWENTIETH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLACK     = 3'd0,
        REG_WHITE     = 3'd1,
        REG_RED_GAIN  = 3'd2,
        REG_BLUE_GAIN = 3'd3,
        REG_SAT       = 3'd4
    } pca_reg_t;

    // Current settings; span is white level minus black level.
    typedef struct packed {
        logic [SLV_W-1:0] black;
        logic [PIX_W-1:0] span;
        logic [PIX_W-1:0] red_gain;
        logic [PIX_W-1:0] blue_gain;
        logic [SLV_W-1:0] sat;
    } pca_cfg_t;

    // Load enables of the four internal pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pca_load_t;

    typedef logic [2:0][PIX_W-1:0] pca_rgb_t;
    typedef logic [2:0][ADJ_W-1:0] pca_adj_t;

endpackage

`default_nettype wire

[hdl/pca_cfg_if.sv]
// Configuration write channel interface.
`default_nettype none

interface pca_cfg_if;
    import pca_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/pca_pix_in_if.sv]
// Input pixel channel interface.
`default_nettype none

interface pca_pix_in_if;
    import pca_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in, input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

`default_nettype wire

[hdl/pca_pix_out_if.sv]
// Adjusted pixel channel interface.
`default_nettype none

interface pca_pix_out_if;
    import pca_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

`default_nettype wire

[hdl/pca_cfg.sv]
// Configuration registers with range saturation on write.
`default_nettype none

module pca_cfg (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pca_cfg_if.sink       cfg,
    output pca_pkg::pca_cfg_t settings
);
    import pca_pkg::*;

    logic signed [SLV_W-1:0] black_reg, black_next;
    logic [PIX_W-1:0]        white_reg, white_next;
    logic [PIX_W-1:0]        red_gain_reg, red_gain_next;
    logic [PIX_W-1:0]        blue_gain_reg, blue_gain_next;
    logic signed [SLV_W-1:0] sat_reg, sat_next;

    logic signed [SLV_W-1:0] raw_s;
    logic [PIX_W-1:0]        raw_u;
    logic signed [SLV_W-1:0] slv_sat;
    logic [PIX_W-1:0]        white_sat;
    logic [PIX_W-1:0]        gain_sat;
    logic signed [PIX_W+1:0] span_s;

    assign cfg.ready = 1'b1;

    assign raw_s = $signed(cfg.data[SLV_W-1:0]);
    assign raw_u = cfg.data[PIX_W-1:0];

    assign slv_sat   = (raw_s < SLV_MIN) ? SLV_MIN : ((raw_s > SLV_MAX) ? SLV_MAX : raw_s);
    assign white_sat = (raw_u < WHITE_MIN) ? WHITE_MIN
                     : ((raw_u > WHITE_MAX) ? WHITE_MAX : raw_u);
    assign gain_sat  = (raw_u < GAIN_MIN) ? GAIN_MIN
                     : ((raw_u > GAIN_MAX) ? GAIN_MAX : raw_u);

    always_comb
    begin
        black_next     = black_reg;
        white_next     = white_reg;
        red_gain_next  = red_gain_reg;
        blue_gain_next = blue_gain_reg;
        sat_next       = sat_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_BLACK:     black_next     = slv_sat;
                REG_WHITE:     white_next     = white_sat;
                REG_RED_GAIN:  red_gain_next  = gain_sat;
                REG_BLUE_GAIN: blue_gain_next = gain_sat;
                REG_SAT:       sat_next       = slv_sat;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_reg     <= '0;
            white_reg     <= ONE_PIX;
            red_gain_reg  <= ONE_PIX;
            blue_gain_reg <= ONE_PIX;
            sat_reg       <= '0;
        end
        else
        begin
            black_reg     <= black_next;
            white_reg     <= white_next;
            red_gain_reg  <= red_gain_next;
            blue_gain_reg <= blue_gain_next;
            sat_reg       <= sat_next;
        end
    end

    // The span stays within the positive 13-bit range for all legal settings.
    assign span_s = $signed({2'b00, white_reg}) - (PIX_W+2)'(black_reg);

    assign settings.black     = black_reg;
    assign settings.span      = span_s[PIX_W-1:0];
    assign settings.red_gain  = red_gain_reg;
    assign settings.blue_gain = blue_gain_reg;
    assign settings.sat       = sat_reg;

endmodule

`default_nettype wire

[hdl/pca_sat.sv]
// Saturation front end: min/max search, spread product, clamped channel adjustment.
`default_nettype none

module pca_sat (
    input  wire logic              clk,
    input  wire pca_pkg::pca_load_t ld,
    input  wire pca_pkg::pca_rgb_t  rgb,
    input  wire logic [pca_pkg::SLV_W-1:0] sat,
    output pca_pkg::pca_adj_t      adj
);
    import pca_pkg::*;

    localparam int PROD_W = PIX_W + 1 + SLV_W;
    localparam int WORK_W = 16;

    logic [1:0]              mn;
    logic [1:0]              mx;
    logic [PIX_W-1:0]        spread;
    logic signed [PROD_W-1:0] prod_next;

    pca_rgb_t                 c_reg;
    logic [1:0]               mn_reg;
    logic [1:0]               mx_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [PROD_W:0]   prod_rnd;
    logic signed [WORK_W-1:0] d0;
    logic signed [WORK_W-1:0] d1;
    logic signed [WORK_W-1:0] d2;
    logic signed [WORK_W-1:0] cmx;
    logic signed [WORK_W-1:0] cmn;
    pca_adj_t                 adj_next;
    pca_adj_t                 adj_reg;

    // Ties go to the lower channel index.
    always_comb
    begin
        mn = 2'd0;
        mx = 2'd0;
        if (rgb[1] < rgb[mn])
            mn = 2'd1;
        if (rgb[2] < rgb[mn])
            mn = 2'd2;
        if (rgb[1] > rgb[mx])
            mx = 2'd1;
        if (rgb[2] > rgb[mx])
            mx = 2'd2;
    end

    assign spread    = rgb[mx] - rgb[mn];
    assign prod_next = $signed({1'b0, spread}) * $signed(sat);

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            c_reg    <= rgb;
            mn_reg   <= mn;
            mx_reg   <= mx;
            prod_reg <= prod_next;
        end
    end

    assign prod_rnd = (PROD_W+1)'(prod_reg) + (PROD_W+1)'(HALF);
    assign d0       = WORK_W'(prod_rnd >>> FRAC_BITS);
    assign cmx      = $signed({{(WORK_W-PIX_W){1'b0}}, c_reg[mx_reg]});
    assign cmn      = $signed({{(WORK_W-PIX_W){1'b0}}, c_reg[mn_reg]});

    // Keep the largest channel at or below one, then the smallest at or above zero.
    assign d1 = (cmx + d0 > WORK_W'(ONE)) ? WORK_W'(ONE) - cmx : d0;
    assign d2 = (cmn - d1 < 0) ? cmn : d1;

    always_comb
    begin
        logic signed [WORK_W-1:0] a;
        for (int i = 0; i < 3; i++)
        begin
            a = $signed({{(WORK_W-PIX_W){1'b0}}, c_reg[i]});
            if (mx_reg == 2'(i))
                a = a + d2;
            if (mn_reg == 2'(i))
                a = a - d2;
            adj_next[i] = a[ADJ_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s2)
            adj_reg <= adj_next;
    end

    assign adj = adj_reg;

endmodule

`default_nettype wire

[hdl/pca_lane.sv]
// One channel lane: levels map, gain product, rounding and final clamp.
`default_nettype none

module pca_lane (
    input  wire logic                       clk,
    input  wire pca_pkg::pca_load_t         ld,
    input  wire logic [pca_pkg::ADJ_W-1:0]  chan,
    input  wire logic [pca_pkg::PIX_W-1:0]  span,
    input  wire logic [pca_pkg::SLV_W-1:0]  black,
    input  wire logic [pca_pkg::PIX_W-1:0]  gain,
    output logic [pca_pkg::PIX_W-1:0]       res
);
    import pca_pkg::*;

    localparam int P1_W  = PIX_W + ADJ_W;
    localparam int Q_W   = P1_W - FRAC_BITS;
    localparam int LVL_W = Q_W + 2;
    localparam int P2_W  = LVL_W + PIX_W + 1;

    logic [P1_W-1:0]         p1_next;
    logic [P1_W-1:0]         p1_reg;
    logic [P1_W-1:0]         p1_rnd;
    logic [Q_W-1:0]          q;
    logic signed [LVL_W-1:0] lvl;
    logic signed [P2_W-1:0]  p2_next;
    logic signed [P2_W-1:0]  p2_reg;
    logic signed [P2_W-1:0]  p2_rnd;
    logic signed [P2_W-1:0]  r;

    assign p1_next = {{ADJ_W{1'b0}}, span} * {{PIX_W{1'b0}}, chan};

    always_ff @(posedge clk)
    begin
        if (ld.s3)
            p1_reg <= p1_next;
    end

    assign p1_rnd = p1_reg + P1_W'(HALF);
    assign q      = Q_W'(p1_rnd >> FRAC_BITS);
    assign lvl    = $signed({2'b00, q}) + LVL_W'($signed(black));

    assign p2_next = lvl * $signed({1'b0, gain});

    always_ff @(posedge clk)
    begin
        if (ld.s4)
            p2_reg <= p2_next;
    end

    assign p2_rnd = p2_reg + P2_W'(HALF);
    assign r      = p2_rnd >>> FRAC_BITS;
    assign res    = (r < 0) ? '0 : ((r > ONE) ? ONE_PIX : r[PIX_W-1:0]);

endmodule

`default_nettype wire

[hdl/pca_merge.sv]
// Output stage that joins the three lane results into one pixel transaction.
`default_nettype none

module pca_merge (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire pca_pkg::pca_rgb_t res,
    output logic                   ready,
    pca_pix_out_if.source          adjusted
);
    import pca_pkg::*;

    logic     valid_reg, valid_next;
    pca_rgb_t data_reg;

    assign ready      = !valid_reg || adjusted.ready;
    assign valid_next = ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ready)
            data_reg <= res;
    end

    assign adjusted.valid     = valid_reg;
    assign adjusted.red_out   = data_reg[0];
    assign adjusted.green_out = data_reg[1];
    assign adjusted.blue_out  = data_reg[2];

endmodule

`default_nettype wire

[hdl/pixel_color_adjust_unit.sv]
// A pixel passes the internal pipeline stages, then the merge register, to the output.
// Throughput: one pixel per clock unless output stalls; one multiplier per lane stage.
// Each stage holds its data only while the next one is full, so bubbles close up
// and new pixels are taken while a finished result waits at the output.
// Reset clears all pipeline valid bits and returns every setting to its default.
`default_nettype none

`include "pixel_color_adjust_unit_macros.svh"

module pixel_color_adjust_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    pca_cfg_if.sink   cfg,
    pca_pix_in_if.sink pixel,
    pca_pix_out_if.source adjusted
);
    import pca_pkg::*;

    pca_cfg_t  settings;
    pca_load_t ld;
    logic      merge_ready;
    logic [3:0] stage_valid_reg, stage_valid_next;
    pca_rgb_t  rgb_in;
    pca_adj_t  adj;
    pca_rgb_t  res;

    assign ld.s4 = !stage_valid_reg[3] || merge_ready;
    assign ld.s3 = !stage_valid_reg[2] || ld.s4;
    assign ld.s2 = !stage_valid_reg[1] || ld.s3;
    assign ld.s1 = !stage_valid_reg[0] || ld.s2;

    assign pixel.ready = ld.s1;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (ld.s1)
            stage_valid_next[0] = pixel.valid;
        if (ld.s2)
            stage_valid_next[1] = stage_valid_reg[0];
        if (ld.s3)
            stage_valid_next[2] = stage_valid_reg[1];
        if (ld.s4)
            stage_valid_next[3] = stage_valid_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= '0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    assign rgb_in = {pixel.blue_in, pixel.green_in, pixel.red_in};

    pca_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    pca_sat u_sat (
        .clk (clk),
        .ld  (ld),
        .rgb (rgb_in),
        .sat (settings.sat),
        .adj (adj)
    );

    pca_lane u_lane_red (
        .clk   (clk),
        .ld    (ld),
        .chan  (adj[0]),
        .span  (settings.span),
        .black (settings.black),
        .gain  (settings.red_gain),
        .res   (res[0])
    );

    // Green has unity gain, which the rounding step passes through exactly.
    pca_lane u_lane_green (
        .clk   (clk),
        .ld    (ld),
        .chan  (adj[1]),
        .span  (settings.span),
        .black (settings.black),
        .gain  (ONE_PIX),
        .res   (res[1])
    );

    pca_lane u_lane_blue (
        .clk   (clk),
        .ld    (ld),
        .chan  (adj[2]),
        .span  (settings.span),
        .black (settings.black),
        .gain  (settings.blue_gain),
        .res   (res[2])
    );

    pca_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stage_valid_reg[3]),
        .res      (res),
        .ready    (merge_ready),
        .adjusted (adjusted)
    );

    `PCA_ASSERT_NEXT(a_first_stage_holds, stage_valid_reg[0] && !ld.s2, stage_valid_reg[0])
    `PCA_ASSERT_NOW(a_accept_when_empty, !stage_valid_reg[0], pixel.ready)
    `PCA_ASSERT_NEXT(a_output_drains, adjusted.valid && adjusted.ready && !stage_valid_reg[3], !adjusted.valid)
    `PCA_ASSERT_NOW(a_green_in_range, adjusted.valid, adjusted.green_out <= ONE_PIX)

endmodule

`default_nettype wire
